// File: rtl/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a property holds on every rising edge of clk_i outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Assert that an antecedent implies a consequent on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/ubfp_pkg.sv
// ----------------------------------------------------------------------------
// ubfp_pkg
// Types, phase codes and protocol constants of the bootloader sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package ubfp_pkg;
  localparam int unsigned PhW = 6;
  localparam logic [PhW-1:0] P_OFF_N = 6'd0, P_WAIT_OFF_N = 6'd1, P_ON_N = 6'd2,
    P_WAIT_ON_N = 6'd3, P_PROBE_TX = 6'd4, P_PROBE_RX = 6'd5, P_OFF_R = 6'd6,
    P_ON_R = 6'd7, P_OFF_B = 6'd8, P_WAIT_OFF_B = 6'd9, P_ON_B = 6'd10,
    P_WAIT_ON_B = 6'd11, P_SYNC_TX = 6'd12, P_SYNC_RX = 6'd13, P_SYNC2_TX = 6'd14,
    P_SYNC2_RX = 6'd15, P_GET_TX = 6'd16, P_GET_ACK = 6'd17, P_GET_NUM = 6'd18,
    P_GET_LIST = 6'd19, P_GET_END = 6'd20, P_ERASE_TX = 6'd21, P_ERASE_ACK = 6'd22,
    P_ERASE_ARG_TX = 6'd23, P_ERASE_DONE = 6'd24, P_UNPROT_TX = 6'd25,
    P_UNPROT_ACK1 = 6'd26, P_UNPROT_ACK2 = 6'd27, P_ERASE_WAIT = 6'd28,
    P_RESYNC_TX = 6'd29, P_RESYNC_RX = 6'd30, P_WR_CMD_TX = 6'd31,
    P_WR_CMD_ACK = 6'd32, P_WR_ADDR_TX = 6'd33, P_WR_ADDR_ACK = 6'd34,
    P_WR_LEN_TX = 6'd35, P_WR_DATA = 6'd36, P_WR_DATA_ACK = 6'd37,
    P_RP_TX = 6'd38, P_RP_ACK1 = 6'd39, P_RP_ACK2 = 6'd40;

  localparam logic [7:0] BL_ACK = 8'h79, BL_NACK = 8'h1F, BL_SYNC = 8'h7F;
  localparam logic [7:0] CMD_GET = 8'h00, CMD_ERASE = 8'h44, CMD_UNPROT = 8'h92;
  localparam logic [7:0] CMD_WRITE = 8'h31, CMD_RPROT = 8'h82;
  localparam logic [7:0] CHR_O = 8'h4F, CHR_E = 8'h45;

  typedef enum logic [1:0] {ST_BUSY = 2'd0, ST_OK = 2'd1, ST_BAD = 2'd2, ST_TIMEOUT = 2'd3}
    status_e;
  typedef enum logic [1:0] {RLY_NONE = 2'd0, RLY_OFF = 2'd1, RLY_ON = 2'd2, RLY_RSVD = 2'd3}
    relay_e;
  typedef enum logic [2:0] {
    REG_POWER = 3'd0, REG_REPLY = 3'd1, REG_ERASE = 3'd2, REG_SEND = 3'd3, REG_PROBE = 3'd4
  } reg_e;

  typedef struct packed {
    logic       tick;
    logic       relay_done;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_ready;
    logic       list_done;
    logic [7:0] fw_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] power_wait_ms;
    logic [15:0] reply_timeout_ms;
    logic [15:0] erase_wait_ms;
    logic [15:0] send_timeout_ms;
    logic [7:0]  probe_byte;
  } cfg_t;

  typedef struct packed {
    logic        link_ready;
    logic [1:0]  status;
    logic [8:0]  list_length;
    logic [15:0] image_index;
    logic        boot_select;
    logic [1:0]  relay_cmd;
    logic [7:0]  tx_byte;
    logic        tx_valid;
  } out_item_t;

  function automatic logic [2:0] seq_len(input logic [PhW-1:0] p);
    case (p)
      P_PROBE_TX, P_SYNC_TX, P_SYNC2_TX, P_RESYNC_TX, P_WR_LEN_TX: seq_len = 3'd1;
      P_GET_TX, P_ERASE_TX, P_UNPROT_TX, P_WR_CMD_TX, P_RP_TX: seq_len = 3'd2;
      P_ERASE_ARG_TX: seq_len = 3'd3;
      P_WR_ADDR_TX: seq_len = 3'd5;
      default: seq_len = 3'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: rtl/ubfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// ubfp_cfg_regs
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none
module ubfp_cfg_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [2:0]        idx_i,
  input  wire logic [15:0]       data_i,
  output ubfp_pkg::cfg_t         cfg_o
);
  import ubfp_pkg::*;
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{16'd1000, 16'd1000, 16'd2000, 16'd100, 8'd0};
    end else if (we_i) begin
      case (reg_e'(idx_i))
        REG_POWER: cfg_q.power_wait_ms <= data_i;
        REG_REPLY: cfg_q.reply_timeout_ms <= data_i;
        REG_ERASE: cfg_q.erase_wait_ms <= data_i;
        REG_SEND:  cfg_q.send_timeout_ms <= data_i;
        REG_PROBE: cfg_q.probe_byte <= data_i[7:0];
        default: ;
      endcase
    end
  end
  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

// File: rtl/ubfp_core.sv
// ----------------------------------------------------------------------------
// ubfp_core
// Sequencer state and one-step next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none
module ubfp_core #(
  parameter int unsigned OffW = 16,
  parameter logic [OffW:0] ImageBytes = '0,
  parameter logic [31:0] FlashBase = 32'h0800_0000
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  ubfp_pkg::in_item_t   in_i,
  input  ubfp_pkg::cfg_t       cfg_i,
  output ubfp_pkg::out_item_t  res_o
);
  import ubfp_pkg::*;

  logic [PhW-1:0] phase_q, phase_d;
  logic [15:0] el_q, el_d;
  logic [1:0] tries_q, tries_d;
  logic [OffW-1:0] off_q, off_d;
  logic [8:0] cnt_q, cnt_d;
  logic [7:0] xor_q, xor_d;
  logic rdy_q, rdy_d, boot_q, boot_d;
  logic [15:0] el;
  logic [2:0] len;
  logic [31:0] addr;
  logic [7:0] sb, cmd;
  logic [OffW:0] nxt;
  logic to, rep;
  out_item_t r;

  always_comb begin
    el = (in_i.tick && el_q != 16'hFFFF) ? el_q + 16'd1 : el_q;
    len = seq_len(phase_q);
    addr = FlashBase + 32'(off_q);
    nxt = {1'b0, off_q} + (OffW+1)'(256);
    to = el >= cfg_i.reply_timeout_ms;
    rep = in_i.rx_valid;
    case (phase_q)
      P_GET_TX: cmd = CMD_GET;
      P_ERASE_TX: cmd = CMD_ERASE;
      P_UNPROT_TX: cmd = CMD_UNPROT;
      P_WR_CMD_TX: cmd = CMD_WRITE;
      default: cmd = CMD_RPROT;
    endcase
    case (phase_q)
      P_PROBE_TX: sb = cfg_i.probe_byte;
      P_SYNC_TX, P_SYNC2_TX, P_RESYNC_TX: sb = BL_SYNC;
      P_WR_LEN_TX: sb = 8'hFF;
      P_ERASE_ARG_TX: sb = (cnt_q < 9'd2) ? 8'hFF : 8'h00;
      P_WR_ADDR_TX: begin
        case (cnt_q[2:0])
          3'd0: sb = addr[31:24];
          3'd1: sb = addr[23:16];
          3'd2: sb = addr[15:8];
          3'd3: sb = addr[7:0];
          default: sb = addr[31:24] ^ addr[23:16] ^ addr[15:8] ^ addr[7:0];
        endcase
      end
      default: sb = (cnt_q == 9'd0) ? cmd : ~cmd;
    endcase

    phase_d = phase_q; el_d = el; tries_d = tries_q; off_d = off_q; cnt_d = cnt_q;
    xor_d = xor_q; rdy_d = rdy_q; boot_d = boot_q;
    r = '0;

    if (len != 3'd0) begin
      if (in_i.tx_ready) begin
        r.tx_valid = 1'b1;
        r.tx_byte = sb;
        cnt_d = cnt_q + 9'd1;
        if (cnt_d >= {6'd0, len}) begin
          phase_d = phase_q + PhW'(1);
          cnt_d = '0;
          if (phase_d == P_WR_DATA) begin
            el_d = '0;
            xor_d = 8'hFF;
          end
        end
      end else if (to) begin
        rep = 1'b0;
        phase_d = P_OFF_N;
      end
    end
    // Transition handling for phases without a byte sequence; reply timeouts follow below.
    if (len == 3'd0) begin
      case (phase_q)
        P_OFF_N: begin
          r.relay_cmd = RLY_OFF;
          if (in_i.relay_done) begin
            boot_d = 1'b0; rdy_d = 1'b0; phase_d = P_WAIT_OFF_N;
          end
        end
        P_WAIT_OFF_N: if (el >= cfg_i.power_wait_ms) phase_d = P_ON_N;
        P_ON_N: begin
          r.relay_cmd = RLY_ON;
          if (in_i.relay_done) phase_d = P_WAIT_ON_N;
        end
        P_WAIT_ON_N: if (el >= cfg_i.power_wait_ms) phase_d = P_PROBE_TX;
        P_PROBE_RX: if (rep && (in_i.rx_byte == CHR_O || in_i.rx_byte == CHR_E))
          phase_d = P_OFF_R;
        P_OFF_R: begin
          r.relay_cmd = RLY_OFF;
          if (in_i.relay_done) begin
            boot_d = 1'b0; phase_d = P_ON_R;
          end
        end
        P_ON_R: begin
          r.relay_cmd = RLY_ON;
          if (in_i.relay_done) begin
            rdy_d = 1'b1; r.status = ST_OK; phase_d = P_OFF_N;
          end
        end
        P_OFF_B: begin
          r.relay_cmd = RLY_OFF;
          if (in_i.relay_done) begin
            boot_d = 1'b1; rdy_d = 1'b0; phase_d = P_WAIT_OFF_B;
          end
        end
        P_WAIT_OFF_B: if (el >= cfg_i.power_wait_ms) phase_d = P_ON_B;
        P_ON_B: begin
          r.relay_cmd = RLY_ON;
          if (in_i.relay_done) phase_d = P_WAIT_ON_B;
        end
        P_WAIT_ON_B: if (el >= cfg_i.power_wait_ms) phase_d = P_SYNC_TX;
        P_SYNC_RX: if (rep) phase_d = (in_i.rx_byte == BL_ACK || in_i.rx_byte == BL_NACK)
          ? P_GET_TX : P_SYNC2_TX;
        P_SYNC2_RX: if (rep) begin
          if (in_i.rx_byte == BL_ACK || in_i.rx_byte == BL_NACK) phase_d = P_GET_TX;
          else begin r.status = ST_BAD; phase_d = P_OFF_N; end
        end
        P_GET_ACK, P_GET_END, P_UNPROT_ACK1, P_UNPROT_ACK2, P_WR_CMD_ACK,
        P_WR_ADDR_ACK, P_RP_ACK1: if (rep) begin
          if (in_i.rx_byte != BL_ACK) begin
            r.status = ST_BAD; phase_d = P_OFF_N;
          end else begin
            case (phase_q)
              P_GET_ACK: phase_d = P_GET_NUM;
              P_GET_END: phase_d = P_ERASE_TX;
              P_UNPROT_ACK1: phase_d = P_UNPROT_ACK2;
              P_UNPROT_ACK2: phase_d = P_ERASE_WAIT;
              P_WR_CMD_ACK: phase_d = P_WR_ADDR_TX;
              P_WR_ADDR_ACK: phase_d = P_WR_LEN_TX;
              default: phase_d = P_RP_ACK2;
            endcase
          end
        end
        P_GET_NUM: if (rep) begin
          r.list_length = {1'b0, in_i.rx_byte} + 9'd1; phase_d = P_GET_LIST;
        end
        P_GET_LIST: begin
          rep = 1'b0;
          if (in_i.list_done) phase_d = P_GET_END;
          else if (to) begin r.status = ST_TIMEOUT; phase_d = P_OFF_N; end
        end
        P_ERASE_ACK: if (rep) begin
          if (in_i.rx_byte == BL_ACK) phase_d = P_ERASE_ARG_TX;
          else if (in_i.rx_byte == BL_NACK) phase_d = P_UNPROT_TX;
          else begin r.status = ST_BAD; phase_d = P_OFF_N; end
        end
        P_ERASE_DONE, P_RESYNC_RX: if (rep) begin
          if (in_i.rx_byte == BL_ACK) begin off_d = '0; phase_d = P_WR_CMD_TX; end
          else begin r.status = ST_BAD; phase_d = P_OFF_N; end
        end
        P_ERASE_WAIT: if (el >= cfg_i.erase_wait_ms) phase_d = P_RESYNC_TX;
        P_WR_DATA: begin
          rep = 1'b0;
          if (in_i.tx_ready) begin
            r.tx_valid = 1'b1;
            if (cnt_q < 9'd256) begin
              r.tx_byte = in_i.fw_byte;
              xor_d = xor_q ^ in_i.fw_byte;
              cnt_d = cnt_q + 9'd1;
            end else begin
              r.tx_byte = xor_q; phase_d = P_WR_DATA_ACK;
            end
          end else if (el >= cfg_i.send_timeout_ms) begin
            r.status = ST_TIMEOUT; phase_d = P_OFF_N;
          end
        end
        P_WR_DATA_ACK: if (rep) begin
          if (in_i.rx_byte != BL_ACK) begin r.status = ST_BAD; phase_d = P_OFF_N; end
          else if (nxt >= ImageBytes) phase_d = P_RP_TX;
          else begin off_d = nxt[OffW-1:0]; phase_d = P_WR_CMD_TX; end
        end
        P_RP_ACK2: if (rep) begin
          if (in_i.rx_byte == BL_ACK) begin
            boot_d = 1'b0; rdy_d = 1'b1; r.status = ST_OK; phase_d = P_OFF_N;
          end else begin r.status = ST_BAD; phase_d = P_OFF_N; end
        end
        default: phase_d = P_OFF_N;
      endcase
    end

    // Reply timeout for waits that expect a byte (also stalled transmits).
    if (((len != 3'd0 && !in_i.tx_ready) ||
         (len == 3'd0 && !in_i.rx_valid && (phase_q == P_PROBE_RX || phase_q == P_SYNC_RX ||
          phase_q == P_SYNC2_RX || phase_q == P_GET_ACK || phase_q == P_GET_NUM ||
          phase_q == P_GET_END || phase_q == P_ERASE_ACK || phase_q == P_ERASE_DONE ||
          phase_q == P_RESYNC_RX || phase_q == P_UNPROT_ACK1 || phase_q == P_UNPROT_ACK2 ||
          phase_q == P_WR_CMD_ACK || phase_q == P_WR_ADDR_ACK || phase_q == P_WR_DATA_ACK ||
          phase_q == P_RP_ACK1 || phase_q == P_RP_ACK2))) && to) begin
      if (phase_q == P_PROBE_TX || phase_q == P_PROBE_RX) begin
        tries_d = '0; phase_d = P_OFF_B;
      end else if (phase_q == P_SYNC_TX || phase_q == P_SYNC_RX) begin
        if (tries_q >= 2'd2) begin r.status = ST_TIMEOUT; phase_d = P_OFF_N; end
        else begin tries_d = tries_q + 2'd1; phase_d = P_OFF_B; end
      end else begin
        r.status = ST_TIMEOUT; phase_d = P_OFF_N;
      end
    end

    // Phase changes clear timer and byte count; ending a byte sequence keeps the timer but for P_WR_DATA.
    if (phase_d != phase_q && !(len != 3'd0 && in_i.tx_ready)) begin
      el_d = '0; cnt_d = '0;
    end
    if (phase_q == P_WR_DATA_ACK && phase_d == P_WR_CMD_TX) begin
      el_d = '0; cnt_d = '0;
    end

    r.boot_select = boot_d;
    r.link_ready = rdy_d;
    r.image_index = 16'(off_d) + ((phase_d == P_WR_DATA) ? 16'(cnt_d) : 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_OFF_N; el_q <= '0; tries_q <= '0; off_q <= '0; cnt_q <= '0;
      xor_q <= 8'hFF; rdy_q <= 1'b0; boot_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d; el_q <= el_d; tries_q <= tries_d; off_q <= off_d;
      cnt_q <= cnt_d; xor_q <= xor_d; rdy_q <= rdy_d; boot_q <= boot_d;
    end
  end

  assign res_o = r;
endmodule
`default_nettype wire

// File: rtl/uart_bootloader_flash_programmer.sv
// ----------------------------------------------------------------------------
// uart_bootloader_flash_programmer
// Host-side serial bootloader sequencer: power cycling, sync, erase, write.
// ----------------------------------------------------------------------------
// Channel    Direction  Content
// s_axis     in         one poll of tick, relay, UART and image byte
// m_axis     out        one result item per input item
// cfg        in         register index and write data
// One item is accepted per cycle; its result is registered and appears the
// next cycle. The state step and result register advance together, so the
// result register is the only stage; s_axis_tready follows output space.
// Reset is asynchronous and restores the power-off step and default registers.
// A stalled m_axis holds the result and stops intake until it is taken.
`default_nettype none
module uart_bootloader_flash_programmer #(
  parameter int unsigned IMAGE_BYTES = 65536,
  parameter logic [31:0] FLASH_BASE = 32'h0800_0000
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output wire logic        s_axis_tready,
  // tick, relay_done, rx_valid, rx_byte, tx_ready, list_done, fw_byte
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic        m_axis_tready,
  output wire logic        m_axis_tvalid,
  // tx_valid, tx_byte, relay_cmd, boot_select, image_index, list_length,
  // status, link_ready
  output wire logic [39:0] m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output wire logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import ubfp_pkg::*;
  localparam int unsigned OffW = $clog2(IMAGE_BYTES + 255);

  in_item_t in_item;
  out_item_t res, res_q;
  cfg_t cfg;
  logic vld_q, step;

  assign in_item = '{s_axis_tdata[0], s_axis_tdata[1], s_axis_tdata[2], s_axis_tdata[10:3],
                     s_axis_tdata[11], s_axis_tdata[12], s_axis_tdata[20:13]};
  assign s_axis_tready = !vld_q || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  ubfp_cfg_regs u_cfg (
    .clk_i, .rst_ni, .we_i(cfg_valid_i), .idx_i(cfg_index_i), .data_i(cfg_data_i),
    .cfg_o(cfg)
  );

  ubfp_core #(
    .OffW(OffW), .ImageBytes((OffW+1)'(IMAGE_BYTES)), .FlashBase(FLASH_BASE)
  ) u_core (
    .clk_i, .rst_ni, .step_i(step), .in_i(in_item), .cfg_i(cfg), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      vld_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata = res_q;
endmodule
`default_nettype wire

// File: rtl/ubfp_checker.sv
// ----------------------------------------------------------------------------
// ubfp_checker
// Port-level checks of the sequencer's result stream.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ubfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  `ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `ASSERT_NEXT(a_out, s_axis_tvalid && s_axis_tready, m_axis_tvalid,
    "accepted item gave no result")
  `ASSERT_CLK(a_relay, !m_axis_tvalid || m_axis_tdata[10:9] != 2'd3, "bad relay code")
  `ASSERT_CLK(a_txb, !m_axis_tvalid || m_axis_tdata[0] || m_axis_tdata[8:1] == 8'd0,
    "tx byte without tx_valid")
endmodule
bind uart_bootloader_flash_programmer ubfp_checker u_chk (.*);
`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Bootloader sequencer testbench
// Drives poll items into the sequencer while a behavioral target answers
// according to the predicted phase. It predicts each result item, checks
// every field, applies random idling and back pressure, and changes registers per test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import ubfp_pkg::*;

  localparam int unsigned ImgBytes = 512;
  localparam logic [31:0] FlashBase = 32'h0800_0000;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    bit       tick;
    bit       relay_done;
    bit       rx_valid;
    bit [7:0] rx_byte;
    bit       tx_ready;
    bit       list_done;
    bit [7:0] fw_byte;
  } poll_t;

  typedef struct {
    bit        tx_valid;
    bit [7:0]  tx_byte;
    bit [1:0]  relay_cmd;
    bit        boot_select;
    bit [15:0] image_index;
    bit [8:0]  list_length;
    bit [1:0]  status;
    bit        link_ready;
  } action_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [39:0] m_axis_tdata;
  wire         cfg_ready_o;

  uart_bootloader_flash_programmer #(
    .IMAGE_BYTES(ImgBytes),
    .FLASH_BASE (FlashBase)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tready(m_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Sequencer state as predicted.
  logic [PhW-1:0] ph = P_OFF_N;
  bit [15:0] el_ms;
  int        tries;
  bit [31:0] blk_off;
  int        cnt;
  bit [7:0]  data_xor = 8'hFF;
  bit        rdy_flag;
  bit        boot_pin;
  bit [1:0]  stat;
  bit [15:0] pwr_wait = 16'd1000, reply_lim = 16'd1000, erase_lim = 16'd2000;
  bit [15:0] send_lim = 16'd100;
  bit [7:0]  probe_val = 8'h00;

  action_t expected_actions[$];
  int  errors, n_items, n_results, n_ok, n_bad, n_timeout, n_programmed;
  int  cycles;
  bit  calm, hold_go;
  int  hold_cnt;
  // Target behavior knobs.
  int  tick_pct = 30, ack_pct = 90, oe_pct = 10, nack_pct = 30;

  function automatic int tx_len(logic [PhW-1:0] p);
    case (p)
      P_PROBE_TX, P_SYNC_TX, P_SYNC2_TX, P_RESYNC_TX, P_WR_LEN_TX: return 1;
      P_GET_TX, P_ERASE_TX, P_UNPROT_TX, P_WR_CMD_TX, P_RP_TX: return 2;
      P_ERASE_ARG_TX: return 3;
      P_WR_ADDR_TX: return 5;
      default: return 0;
    endcase
  endfunction

  function automatic bit [7:0] tx_seq_byte(logic [PhW-1:0] p, int i);
    bit [31:0] addr;
    bit [7:0]  c;
    addr = FlashBase + blk_off;
    case (p)
      P_PROBE_TX: return probe_val;
      P_SYNC_TX, P_SYNC2_TX, P_RESYNC_TX: return BL_SYNC;
      P_WR_LEN_TX: return 8'hFF;
      P_ERASE_ARG_TX: return (i < 2) ? 8'hFF : 8'h00;
      P_WR_ADDR_TX: begin
        case (i)
          0: return addr[31:24];
          1: return addr[23:16];
          2: return addr[15:8];
          3: return addr[7:0];
          default: return addr[31:24] ^ addr[23:16] ^ addr[15:8] ^ addr[7:0];
        endcase
      end
      P_GET_TX: c = CMD_GET;
      P_ERASE_TX: c = CMD_ERASE;
      P_UNPROT_TX: c = CMD_UNPROT;
      P_WR_CMD_TX: c = CMD_WRITE;
      default: c = CMD_RPROT;
    endcase
    return (i == 0) ? c : ~c;
  endfunction

  function automatic void go_to(logic [PhW-1:0] p);
    ph = p;
    el_ms = '0;
    cnt = 0;
  endfunction

  function automatic void conclude(bit [1:0] code);
    stat = code;
    case (code)
      ST_OK: n_ok++;
      ST_BAD: n_bad++;
      default: n_timeout++;
    endcase
    go_to(P_OFF_N);
  endfunction

  function automatic void reply_late();
    if (ph == P_PROBE_TX || ph == P_PROBE_RX) begin
      tries = 0;
      go_to(P_OFF_B);
    end else if (ph == P_SYNC_TX || ph == P_SYNC_RX) begin
      if (tries >= 2) begin
        conclude(ST_TIMEOUT);
      end else begin
        tries++;
        go_to(P_OFF_B);
      end
    end else begin
      conclude(ST_TIMEOUT);
    end
  endfunction

  function automatic bit got_reply(bit rxv);
    if (rxv) return 1'b1;
    if (el_ms >= reply_lim) reply_late();
    return 1'b0;
  endfunction

  function automatic void need_ack(poll_t p, logic [PhW-1:0] nxt);
    if (got_reply(p.rx_valid)) begin
      if (p.rx_byte == BL_ACK) go_to(nxt);
      else conclude(ST_BAD);
    end
  endfunction

  function automatic action_t sequencer_step(poll_t p);
    action_t a;
    int      n;
    bit [31:0] nxt;
    a = '{default: '0};
    stat = ST_BUSY;
    if (p.tick && el_ms != 16'hFFFF) el_ms++;
    n = tx_len(ph);
    if (n != 0) begin
      if (p.tx_ready) begin
        a.tx_valid = 1'b1;
        a.tx_byte = tx_seq_byte(ph, cnt);
        cnt++;
        if (cnt >= n) begin
          ph = ph + 1'b1;
          cnt = 0;
          if (ph == P_WR_DATA) begin
            el_ms = '0;
            data_xor = 8'hFF;
          end
        end
      end else if (el_ms >= reply_lim) begin
        reply_late();
      end
    end else begin
      case (ph)
        P_OFF_N: begin
          a.relay_cmd = RLY_OFF;
          if (p.relay_done) begin
            boot_pin = 0;
            rdy_flag = 0;
            go_to(P_WAIT_OFF_N);
          end
        end
        P_WAIT_OFF_N: if (el_ms >= pwr_wait) go_to(P_ON_N);
        P_ON_N: begin
          a.relay_cmd = RLY_ON;
          if (p.relay_done) go_to(P_WAIT_ON_N);
        end
        P_WAIT_ON_N: if (el_ms >= pwr_wait) go_to(P_PROBE_TX);
        P_PROBE_RX: begin
          if (got_reply(p.rx_valid) && (p.rx_byte == CHR_O || p.rx_byte == CHR_E))
            go_to(P_OFF_R);
        end
        P_OFF_R: begin
          a.relay_cmd = RLY_OFF;
          if (p.relay_done) begin
            boot_pin = 0;
            go_to(P_ON_R);
          end
        end
        P_ON_R: begin
          a.relay_cmd = RLY_ON;
          if (p.relay_done) begin
            rdy_flag = 1;
            conclude(ST_OK);
          end
        end
        P_OFF_B: begin
          a.relay_cmd = RLY_OFF;
          if (p.relay_done) begin
            boot_pin = 1;
            rdy_flag = 0;
            go_to(P_WAIT_OFF_B);
          end
        end
        P_WAIT_OFF_B: if (el_ms >= pwr_wait) go_to(P_ON_B);
        P_ON_B: begin
          a.relay_cmd = RLY_ON;
          if (p.relay_done) go_to(P_WAIT_ON_B);
        end
        P_WAIT_ON_B: if (el_ms >= pwr_wait) go_to(P_SYNC_TX);
        P_SYNC_RX: begin
          if (got_reply(p.rx_valid))
            go_to((p.rx_byte == BL_ACK || p.rx_byte == BL_NACK) ? P_GET_TX : P_SYNC2_TX);
        end
        P_SYNC2_RX: begin
          if (got_reply(p.rx_valid)) begin
            if (p.rx_byte == BL_ACK || p.rx_byte == BL_NACK) go_to(P_GET_TX);
            else conclude(ST_BAD);
          end
        end
        P_GET_ACK: need_ack(p, P_GET_NUM);
        P_GET_NUM: begin
          if (got_reply(p.rx_valid)) begin
            a.list_length = p.rx_byte + 9'd1;
            go_to(P_GET_LIST);
          end
        end
        P_GET_LIST: begin
          if (p.list_done) go_to(P_GET_END);
          else if (el_ms >= reply_lim) conclude(ST_TIMEOUT);
        end
        P_GET_END: need_ack(p, P_ERASE_TX);
        P_ERASE_ACK: begin
          if (got_reply(p.rx_valid)) begin
            if (p.rx_byte == BL_ACK) go_to(P_ERASE_ARG_TX);
            else if (p.rx_byte == BL_NACK) go_to(P_UNPROT_TX);
            else conclude(ST_BAD);
          end
        end
        P_ERASE_DONE, P_RESYNC_RX: begin
          if (got_reply(p.rx_valid)) begin
            if (p.rx_byte == BL_ACK) begin
              blk_off = 0;
              go_to(P_WR_CMD_TX);
            end else begin
              conclude(ST_BAD);
            end
          end
        end
        P_UNPROT_ACK1: need_ack(p, P_UNPROT_ACK2);
        P_UNPROT_ACK2: need_ack(p, P_ERASE_WAIT);
        P_ERASE_WAIT: if (el_ms >= erase_lim) go_to(P_RESYNC_TX);
        P_WR_CMD_ACK: need_ack(p, P_WR_ADDR_TX);
        P_WR_ADDR_ACK: need_ack(p, P_WR_LEN_TX);
        P_WR_DATA: begin
          if (p.tx_ready) begin
            a.tx_valid = 1'b1;
            if (cnt < 256) begin
              a.tx_byte = p.fw_byte;
              data_xor ^= p.fw_byte;
              cnt++;
            end else begin
              a.tx_byte = data_xor;
              go_to(P_WR_DATA_ACK);
            end
          end else if (el_ms >= send_lim) begin
            conclude(ST_TIMEOUT);
          end
        end
        P_WR_DATA_ACK: begin
          if (got_reply(p.rx_valid)) begin
            if (p.rx_byte != BL_ACK) begin
              conclude(ST_BAD);
            end else begin
              nxt = blk_off + 256;
              if (nxt >= ImgBytes) begin
                go_to(P_RP_TX);
              end else begin
                blk_off = nxt;
                go_to(P_WR_CMD_TX);
              end
            end
          end
        end
        P_RP_ACK1: need_ack(p, P_RP_ACK2);
        P_RP_ACK2: begin
          if (got_reply(p.rx_valid)) begin
            if (p.rx_byte == BL_ACK) begin
              boot_pin = 0;
              rdy_flag = 1;
              n_programmed++;
              conclude(ST_OK);
            end else begin
              conclude(ST_BAD);
            end
          end
        end
        default: go_to(P_OFF_N);
      endcase
    end
    a.boot_select = boot_pin;
    a.image_index = 16'(blk_off + ((ph == P_WR_DATA) ? cnt : 0));
    a.status = stat;
    a.link_ready = rdy_flag;
    return a;
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Behavioral target: answers depend on the phase the sequencer is in.
  function automatic poll_t target_poll();
    poll_t p;
    bit    waiting;
    p.tick = chance(tick_pct);
    p.relay_done = chance(70);
    p.tx_ready = chance(85);
    p.list_done = chance(30);
    p.fw_byte = 8'($urandom);
    p.rx_byte = 8'($urandom);
    waiting = ph inside {P_PROBE_RX, P_SYNC_RX, P_SYNC2_RX, P_GET_ACK, P_GET_NUM,
                         P_GET_END, P_ERASE_ACK, P_ERASE_DONE, P_UNPROT_ACK1,
                         P_UNPROT_ACK2, P_RESYNC_RX, P_WR_CMD_ACK, P_WR_ADDR_ACK,
                         P_WR_DATA_ACK, P_RP_ACK1, P_RP_ACK2};
    p.rx_valid = waiting ? chance(50) : chance(5);
    case (ph)
      P_PROBE_RX: if (chance(oe_pct)) p.rx_byte = chance(50) ? CHR_O : CHR_E;
      P_SYNC_RX, P_SYNC2_RX: if (chance(80)) p.rx_byte = chance(50) ? BL_ACK : BL_NACK;
      P_GET_NUM: ;
      P_ERASE_ACK: begin
        if (chance(nack_pct)) p.rx_byte = BL_NACK;
        else if (chance(ack_pct)) p.rx_byte = BL_ACK;
      end
      default: if (waiting && chance(ack_pct)) p.rx_byte = BL_ACK;
    endcase
    return p;
  endfunction

  function automatic logic [23:0] pack_poll(poll_t p);
    return {3'b000, p.fw_byte, p.list_done, p.tx_ready, p.rx_byte, p.rx_valid,
            p.relay_done, p.tick};
  endfunction

  task automatic send_poll(poll_t p);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pack_poll(p);
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    expected_actions.push_back(sequencer_step(p));
    n_items++;
    if (!calm && chance(9)) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_target(int n);
    repeat (n) send_poll(target_poll());
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (expected_actions.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [15:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (r)
      REG_POWER: pwr_wait = v;
      REG_REPLY: reply_lim = v;
      REG_ERASE: erase_lim = v;
      REG_SEND: send_lim = v;
      default: probe_val = v[7:0];
    endcase
  endtask

  task automatic set_timing(logic [15:0] pw, logic [15:0] rl, logic [15:0] ew,
                            logic [15:0] sl, logic [7:0] pb);
    write_reg(REG_POWER, pw);
    write_reg(REG_REPLY, rl);
    write_reg(REG_ERASE, ew);
    write_reg(REG_SEND, sl);
    write_reg(REG_PROBE, {8'h00, pb});
  endtask

  // Field extremes with the reset register values: the block sits in the
  // power-off wait while all-zero and all-one polls arrive, then target polls.
  task automatic test_field_extremes();
    poll_t p;
    for (int i = 0; i < 12; i++) begin
      p = '{default: '0};
      if (i[0]) p = '{1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF};
      if (i >= 8) p = target_poll();
      send_poll(p);
    end
  endtask

  // Register extremes: longest power wait holds the sequencer, zero waits and
  // shortest limits let every wait expire on its first item.
  task automatic test_register_extremes();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    tick_pct = 100;
    run_target(12);
    set_timing(16'd0, 16'd1, 16'd0, 16'd1, 8'h00);
    run_target(80);
  endtask

  // Running firmware answers the probe, so the sequencer ends early.
  task automatic test_firmware_present();
    set_timing(16'd2, 16'd30, 16'd1, 16'd60, 8'hA5);
    tick_pct = 25;
    oe_pct = 60;
    run_target(200);
  endtask

  // Full programming runs through sync, get, erase, block writes and protect.
  task automatic test_programming();
    set_timing(16'd1, 16'd60, 16'd2, 16'd400, 8'h5A);
    tick_pct = 10;
    oe_pct = 3;
    ack_pct = 98;
    nack_pct = 35;
    calm = 1;
    run_target(350);
    calm = 0;
    run_target(650);
  endtask

  // The receiver holds off while polls keep coming.
  task automatic test_output_stall();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    run_target(150);
  endtask

  // Short limits and poor replies exercise timeouts and bad replies.
  task automatic test_bad_target();
    set_timing(16'd0, 16'd3, 16'd0, 16'd2, 8'h3C);
    tick_pct = 50;
    ack_pct = 60;
    oe_pct = 15;
    run_target(400);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_go) begin
        hold_cnt <= 300;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || !chance(9);
      end
    end
  end

  always @(negedge clk_i) begin
    action_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (expected_actions.size() == 0) begin
        $error("result item with no expectation: %h", m_axis_tdata);
        errors++;
      end else begin
        e = expected_actions.pop_front();
        if (m_axis_tdata[0] !== e.tx_valid) begin
          $error("tx_valid exp %0d got %0d", e.tx_valid, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[8:1] !== e.tx_byte) begin
          $error("tx_byte exp %h got %h", e.tx_byte, m_axis_tdata[8:1]);
          errors++;
        end
        if (m_axis_tdata[10:9] !== e.relay_cmd) begin
          $error("relay_cmd exp %0d got %0d", e.relay_cmd, m_axis_tdata[10:9]);
          errors++;
        end
        if (m_axis_tdata[11] !== e.boot_select) begin
          $error("boot_select exp %0d got %0d", e.boot_select, m_axis_tdata[11]);
          errors++;
        end
        if (m_axis_tdata[27:12] !== e.image_index) begin
          $error("image_index exp %0d got %0d", e.image_index, m_axis_tdata[27:12]);
          errors++;
        end
        if (m_axis_tdata[36:28] !== e.list_length) begin
          $error("list_length exp %0d got %0d", e.list_length, m_axis_tdata[36:28]);
          errors++;
        end
        if (m_axis_tdata[38:37] !== e.status) begin
          $error("status exp %0d got %0d", e.status, m_axis_tdata[38:37]);
          errors++;
        end
        if (m_axis_tdata[39] !== e.link_ready) begin
          $error("link_ready exp %0d got %0d", e.link_ready, m_axis_tdata[39]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_register_extremes();
    test_firmware_present();
    test_programming();
    test_output_stall();
    test_bad_target();
    drain();
    $display("Sent %0d poll items, checked %0d results.", n_items, n_results);
    $display("Runs: %0d ok (%0d full images), %0d bad reply, %0d timeout.",
             n_ok, n_programmed, n_bad, n_timeout);
    if (errors == 0 && expected_actions.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: uart_bootloader_flash_programmer.f
+incdir+rtl
rtl/ubfp_pkg.sv
rtl/ubfp_cfg_regs.sv
rtl/ubfp_core.sv
rtl/uart_bootloader_flash_programmer.sv
rtl/ubfp_checker.sv
dv/tb.sv
